### rtl/rosi_pkg.sv
// ----------------------------------------------------------------------------
// rosi_pkg
// Shared widths, register codes, reset values and flag types for the
// ray / oriented box slab intersection block.
// ----------------------------------------------------------------------------
package rosi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int T_BITS_DEF     = 32;
  localparam int LANE_BITS      = 16;
  localparam int FRAC_T         = 16;
  localparam int HALF_SHIFT     = 14;   // Q8.8 half-extent to the Q.22 scale
  localparam int CFG_BITS       = 48;
  localparam int AXES           = 3;
  localparam int APB_DATA_W     = 64;
  localparam int APB_ADDR_W     = 6;
  localparam int OUT_T_BITS     = 32;

  localparam logic [CFG_BITS-1:0] CENTER_RST = 48'h0000_0000_0000;
  localparam logic [CFG_BITS-1:0] AXIS_A_RST = 48'h0000_0000_4000;
  localparam logic [CFG_BITS-1:0] AXIS_B_RST = 48'h0000_4000_0000;
  localparam logic [CFG_BITS-1:0] AXIS_C_RST = 48'h4000_0000_0000;
  localparam logic [CFG_BITS-1:0] HALF_RST   = 48'h0100_0100_0100;

  typedef enum logic [2:0] {
    REG_CENTER = 3'd0,
    REG_AXIS_A = 3'd1,
    REG_AXIS_B = 3'd2,
    REG_AXIS_C = 3'd3,
    REG_HALF   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic par;        // direction projection is zero
    logic par_miss;   // parallel and origin outside the slab
    logic neg1;       // sign of the near-plane distance
    logic neg2;       // sign of the far-plane distance
  } slab_flags_t;

  // origin minus center
  function automatic int delta_w(int c);
    return ((c > LANE_BITS) ? c : LANE_BITS) + 1;
  endfunction

  // signed slab numerator: three products summed, plus the half-extent
  function automatic int num_w(int c);
    return delta_w(c) + LANE_BITS + 3;
  endfunction

  // signed direction projection
  function automatic int den_w(int c);
    return c + LANE_BITS + 2;
  endfunction

endpackage

### rtl/ray_obb_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_obb_slab_intersect
// Throughput: one ray per cycle while the output buffer has a free slot;
// the divider retires one quotient bit per stage.
// A two-entry output buffer keeps input flowing while a result waits.
// Reset (synchronous): valid bits and buffer clear, box registers take defaults.
// ----------------------------------------------------------------------------
module ray_obb_slab_intersect import rosi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int T_BITS     = T_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up, zero pad
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // t_near, t_far from bit 0 up
  output logic [2*OUT_T_BITS-1:0] m_tdata,
  // hit
  output logic                  m_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NW = num_w(COORD_BITS);
  localparam int FW = den_w(COORD_BITS);

  logic [CFG_BITS-1:0] center, half;
  logic [CFG_BITS-1:0] axis [AXES];

  logic                         en;
  logic signed [COORD_BITS-1:0] origin [AXES];
  logic signed [COORD_BITS-1:0] dir [AXES];

  logic              p_valid;
  logic [NW-1:0]     n1 [AXES];
  logic [NW-1:0]     n2 [AXES];
  logic [FW-1:0]     dm [AXES];
  slab_flags_t       p_flags [AXES];

  logic [T_BITS-1:0] q1 [AXES];
  logic [T_BITS-1:0] q2 [AXES];
  logic              s1 [AXES];
  logic              s2 [AXES];

  logic              vpipe [T_BITS];
  slab_flags_t       fpipe [T_BITS][AXES];

  logic                  r_valid, r_hit;
  logic [OUT_T_BITS-1:0] r_near, r_far;

  logic                  buf_hit  [2];
  logic [OUT_T_BITS-1:0] buf_near [2];
  logic [OUT_T_BITS-1:0] buf_far  [2];
  logic                  wptr, rptr;
  logic [1:0]            cnt;
  logic                  push, pop;

  rosi_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .center, .axis, .half
  );

  // pipeline moves whenever the output buffer has a free slot
  assign en       = (cnt != 2'd2);
  assign s_tready = en;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      origin[k] = $signed(s_tdata[k*COORD_BITS +: COORD_BITS]);
      dir[k]    = $signed(s_tdata[(k+AXES)*COORD_BITS +: COORD_BITS]);
    end
  end

  rosi_proj #(.COORD_BITS(COORD_BITS)) u_proj (
    .clk, .rst, .en,
    .in_valid (s_tvalid),
    .origin, .dir, .center, .axis, .half,
    .out_valid(p_valid),
    .num1_mag (n1),
    .num2_mag (n2),
    .den_mag  (dm),
    .flags    (p_flags)
  );

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    rosi_div #(.NUM_W(NW), .DEN_W(FW), .Q_BITS(T_BITS)) u_div1 (
      .clk, .en, .num(n1[i]), .den(dm[i]), .quot(q1[i]), .sat(s1[i])
    );
    rosi_div #(.NUM_W(NW), .DEN_W(FW), .Q_BITS(T_BITS)) u_div2 (
      .clk, .en, .num(n2[i]), .den(dm[i]), .quot(q2[i]), .sat(s2[i])
    );
  end

  // side flags and valid ride alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < T_BITS; s++) vpipe[s] <= 1'b0;
    end else if (en) begin
      vpipe[0] <= p_valid;
      for (int s = 1; s < T_BITS; s++) vpipe[s] <= vpipe[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fpipe[0] <= p_flags;
      for (int s = 1; s < T_BITS; s++) fpipe[s] <= fpipe[s-1];
    end
  end

  rosi_resolve #(.Q_BITS(T_BITS)) u_res (
    .clk, .rst, .en,
    .in_valid (vpipe[T_BITS-1]),
    .q1, .s1, .q2, .s2,
    .flags    (fpipe[T_BITS-1]),
    .out_valid(r_valid),
    .hit      (r_hit),
    .t_near   (r_near),
    .t_far    (r_far)
  );

  assign push = en && r_valid;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_hit[wptr]  <= r_hit;
      buf_near[wptr] <= r_near;
      buf_far[wptr]  <= r_far;
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tuser  = buf_hit[rptr];
  assign m_tdata  = {buf_far[rptr], buf_near[rptr]};

endmodule

### rtl/rosi_cfg.sv
// ----------------------------------------------------------------------------
// rosi_cfg
// APB register file holding the box: center, three axes, half-extents.
// ----------------------------------------------------------------------------
module rosi_cfg import rosi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CFG_BITS-1:0]   center,
  output logic [CFG_BITS-1:0]   axis [AXES],
  output logic [CFG_BITS-1:0]   half
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center  <= CENTER_RST;
      axis[0] <= AXIS_A_RST;
      axis[1] <= AXIS_B_RST;
      axis[2] <= AXIS_C_RST;
      half    <= HALF_RST;
    end else if (wr) begin
      unique case (idx)
        REG_CENTER: center  <= pwdata[CFG_BITS-1:0];
        REG_AXIS_A: axis[0] <= pwdata[CFG_BITS-1:0];
        REG_AXIS_B: axis[1] <= pwdata[CFG_BITS-1:0];
        REG_AXIS_C: axis[2] <= pwdata[CFG_BITS-1:0];
        REG_HALF:   half    <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER: prdata = APB_DATA_W'(center);
      REG_AXIS_A: prdata = APB_DATA_W'(axis[0]);
      REG_AXIS_B: prdata = APB_DATA_W'(axis[1]);
      REG_AXIS_C: prdata = APB_DATA_W'(axis[2]);
      REG_HALF:   prdata = APB_DATA_W'(half);
      default:    prdata = '0;
    endcase
  end

endmodule

### rtl/rosi_proj.sv
// ----------------------------------------------------------------------------
// rosi_proj
// Four-stage front end: offset, axis products, projections, then slab
// numerators, magnitudes and parallel-slab test.
// ----------------------------------------------------------------------------
module rosi_proj import rosi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [COORD_BITS-1:0]      origin [AXES],
  input  logic signed [COORD_BITS-1:0]      dir [AXES],
  input  logic [CFG_BITS-1:0]               center,
  input  logic [CFG_BITS-1:0]               axis [AXES],
  input  logic [CFG_BITS-1:0]               half,
  output logic                              out_valid,
  output logic [num_w(COORD_BITS)-1:0]      num1_mag [AXES],
  output logic [num_w(COORD_BITS)-1:0]      num2_mag [AXES],
  output logic [den_w(COORD_BITS)-1:0]      den_mag [AXES],
  output slab_flags_t                       flags [AXES]
);

  localparam int DW = delta_w(COORD_BITS);
  localparam int PW = DW + LANE_BITS;
  localparam int QW = COORD_BITS + LANE_BITS;
  localparam int NW = num_w(COORD_BITS);
  localparam int FW = den_w(COORD_BITS);

  logic                  v1, v2, v3;
  logic signed [DW-1:0]  delta [AXES];
  logic signed [COORD_BITS-1:0] dirr [AXES];
  logic signed [PW-1:0]  pe [AXES][AXES];
  logic signed [QW-1:0]  pf [AXES][AXES];
  logic signed [NW-1:0]  e [AXES];
  logic signed [FW-1:0]  f [AXES];

  logic signed [NW-1:0]  h_c [AXES];
  logic signed [NW-1:0]  n1_c [AXES];
  logic signed [NW-1:0]  n2_c [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        delta[k] <= DW'(origin[k]) - DW'($signed(center[k*LANE_BITS +: LANE_BITS]));
        dirr[k]  <= dir[k];
      end
      for (int i = 0; i < AXES; i++) begin
        for (int k = 0; k < AXES; k++) begin
          pe[i][k] <= PW'($signed(axis[i][k*LANE_BITS +: LANE_BITS])) * PW'(delta[k]);
          pf[i][k] <= QW'($signed(axis[i][k*LANE_BITS +: LANE_BITS])) * QW'(dirr[k]);
        end
        e[i] <= NW'(pe[i][0]) + NW'(pe[i][1]) + NW'(pe[i][2]);
        f[i] <= FW'(pf[i][0]) + FW'(pf[i][1]) + FW'(pf[i][2]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      h_c[i]  = NW'($signed({1'b0, half[i*LANE_BITS +: LANE_BITS], {HALF_SHIFT{1'b0}}}));
      n1_c[i] = -h_c[i] - e[i];
      n2_c[i] = h_c[i] - e[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        num1_mag[i]       <= n1_c[i][NW-1] ? NW'(-n1_c[i]) : NW'(n1_c[i]);
        num2_mag[i]       <= n2_c[i][NW-1] ? NW'(-n2_c[i]) : NW'(n2_c[i]);
        den_mag[i]        <= f[i][FW-1] ? FW'(-f[i]) : FW'(f[i]);
        flags[i].par      <= (f[i] == '0);
        flags[i].par_miss <= (e[i] < -h_c[i]) || (e[i] > h_c[i]);
        flags[i].neg1     <= n1_c[i][NW-1] ^ f[i][FW-1];
        flags[i].neg2     <= n2_c[i][NW-1] ^ f[i][FW-1];
      end
    end
  end

endmodule

### rtl/rosi_div.sv
// ----------------------------------------------------------------------------
// rosi_div
// Pipelined restoring divider, one quotient bit per stage. Gives
// floor(num * 2^16 / den) over Q_BITS bits and flags saturation.
// ----------------------------------------------------------------------------
module rosi_div import rosi_pkg::*; #(
  parameter int NUM_W  = 37,
  parameter int DEN_W  = 34,
  parameter int Q_BITS = T_BITS_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [Q_BITS-1:0] quot,
  output logic              sat
);

  localparam int XW = NUM_W + FRAC_T + DEN_W;
  localparam int SW = NUM_W + DEN_W + Q_BITS;

  logic [XW-1:0]     nx;
  logic [DEN_W-1:0]  rem0;
  logic [Q_BITS-1:0] low0;
  logic              sat0;

  logic [DEN_W-1:0]  rem  [Q_BITS];
  logic [DEN_W-1:0]  dd   [Q_BITS];
  logic [Q_BITS-1:0] low  [Q_BITS];
  logic [Q_BITS-1:0] qq   [Q_BITS];
  logic              satp [Q_BITS];

  // the quotient fits Q_BITS only when num < den * 2^(Q_BITS-16); then the
  // top part of the shifted dividend is already below den
  assign nx   = XW'({num, {FRAC_T{1'b0}}});
  assign rem0 = nx[Q_BITS +: DEN_W];
  assign low0 = nx[Q_BITS-1:0];
  assign sat0 = SW'(num) >= (SW'(den) << (Q_BITS - FRAC_T));

  for (genvar s = 0; s < Q_BITS; s++) begin : g_step
    logic [DEN_W-1:0]  r_in, d_in;
    logic [Q_BITS-1:0] l_in, q_in;
    logic              s_in, ge;
    logic [DEN_W:0]    trial;

    if (s == 0) begin : g_first
      assign r_in = rem0;
      assign d_in = den;
      assign l_in = low0;
      assign q_in = '0;
      assign s_in = sat0;
    end else begin : g_next
      assign r_in = rem[s-1];
      assign d_in = dd[s-1];
      assign l_in = low[s-1];
      assign q_in = qq[s-1];
      assign s_in = satp[s-1];
    end

    assign trial = {r_in, l_in[Q_BITS-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
        dd[s]   <= d_in;
        low[s]  <= l_in << 1;
        qq[s]   <= {q_in[Q_BITS-2:0], ge};
        satp[s] <= s_in;
      end
    end
  end

  assign quot = qq[Q_BITS-1];
  assign sat  = satp[Q_BITS-1];

endmodule

### rtl/rosi_resolve.sv
// ----------------------------------------------------------------------------
// rosi_resolve
// Three-stage back end: signed slab distances and ordering, entry / exit
// narrowing over the axes, then hit decision and output clamping.
// ----------------------------------------------------------------------------
module rosi_resolve import rosi_pkg::*; #(
  parameter int Q_BITS = T_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [Q_BITS-1:0]     q1 [AXES],
  input  logic                  s1 [AXES],
  input  logic [Q_BITS-1:0]     q2 [AXES],
  input  logic                  s2 [AXES],
  input  slab_flags_t           flags [AXES],
  output logic                  out_valid,
  output logic                  hit,
  output logic [OUT_T_BITS-1:0] t_near,
  output logic [OUT_T_BITS-1:0] t_far
);

  localparam int TW = Q_BITS + 1;
  localparam int OW = ((Q_BITS > OUT_T_BITS) ? Q_BITS : OUT_T_BITS) + 1;
  localparam logic signed [TW-1:0] TMAX = $signed({1'b0, {Q_BITS{1'b1}}});

  logic                 v1, v2;
  logic signed [TW-1:0] t1_c [AXES];
  logic signed [TW-1:0] t2_c [AXES];
  logic signed [TW-1:0] lo [AXES];
  logic signed [TW-1:0] hi [AXES];
  logic                 par [AXES];
  logic                 pmiss [AXES];

  logic signed [TW-1:0] enter_c, exit_c;
  logic signed [TW-1:0] enter, exit_t;
  logic                 miss;

  logic                 hit_c;
  logic signed [OW-1:0] enter_x, exit_x;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic [Q_BITS-1:0] m1, m2;
      m1 = s1[i] ? {Q_BITS{1'b1}} : q1[i];
      m2 = s2[i] ? {Q_BITS{1'b1}} : q2[i];
      t1_c[i] = flags[i].neg1 ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
      t2_c[i] = flags[i].neg2 ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
    end
  end

  always_comb begin
    enter_c = -TMAX;
    exit_c  = TMAX;
    for (int i = 0; i < AXES; i++) begin
      if (!par[i]) begin
        if (lo[i] > enter_c) enter_c = lo[i];
        if (hi[i] < exit_c)  exit_c  = hi[i];
      end
    end
  end

  assign hit_c   = !miss && !(enter > exit_t) && !exit_t[TW-1];
  assign enter_x = OW'(enter);
  assign exit_x  = OW'(exit_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        lo[i]    <= (t1_c[i] > t2_c[i]) ? t2_c[i] : t1_c[i];
        hi[i]    <= (t1_c[i] > t2_c[i]) ? t1_c[i] : t2_c[i];
        par[i]   <= flags[i].par;
        pmiss[i] <= flags[i].par && flags[i].par_miss;
      end
      enter  <= enter_c;
      exit_t <= exit_c;
      miss   <= pmiss[0] || pmiss[1] || pmiss[2];
      hit    <= hit_c;
      t_near <= (hit_c && !enter[TW-1]) ? enter_x[OUT_T_BITS-1:0] : '0;
      t_far  <= hit_c ? exit_x[OUT_T_BITS-1:0] : '0;
    end
  end

endmodule

### rtl/rosi_checker.sv
// ----------------------------------------------------------------------------
// rosi_checker
// Port-level checks on the result stream and the register port.
// ----------------------------------------------------------------------------
module rosi_checker import rosi_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [2*OUT_T_BITS-1:0] m_tdata,
  input logic                    m_tuser,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic [APB_ADDR_W-1:0]   paddr,
  input logic [APB_DATA_W-1:0]   pwdata,
  input logic [APB_DATA_W-1:0]   prdata
);

  // a result held back keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a miss reports zero distances
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss with nonzero distances");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // center register reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[APB_ADDR_W-1:3] == REG_CENTER
    |=> paddr[APB_ADDR_W-1:3] != REG_CENTER
        || prdata == APB_DATA_W'($past(pwdata[CFG_BITS-1:0])))
    else $error("register readback mismatch");

endmodule

bind ray_obb_slab_intersect rosi_checker u_chk (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench for ray_obb_slab_intersect
// Streams rays against several box settings written over APB. A directed
// table covers extremes and the parallel, inside and miss cases; random rays
// follow. Every result is compared against a fixed-point slab predictor.
// ----------------------------------------------------------------------------
module testbench import rosi_pkg::*;;

  localparam int CB    = 16;
  localparam int TB    = 32;
  localparam int DW    = ((6*CB+7)/8)*8;
  localparam int LIMIT = 20000;
  localparam longint TMAX = (64'd1 << TB) - 1;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_near;
    logic [31:0] t_far;
  } ray_res_t;

  typedef struct {
    logic [15:0] o [3];
    logic [15:0] d [3];
    bit          chk;
    ray_res_t    res;
  } ray_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [63:0] m_tdata;
  logic m_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic [47:0] box [5];
  ray_res_t hit_queue [$];
  int errors = 0, rays_sent = 0, hits_seen = 0, results_seen = 0;
  int idle_cnt = 0;
  int out_stall = 0;
  bit  quiet = 0;

  always #5 clk = ~clk;

  ray_obb_slab_intersect #(.COORD_BITS(CB), .T_BITS(TB)) i_dut (.*);

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  // Q.16 quotient, truncated toward zero, magnitude saturated at TMAX
  function automatic longint slab_t(longint num, longint den);
    longint unsigned n, d, q, r, mag;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    if (q > (TMAX >> 16)) mag = TMAX;
    else mag = (q << 16) | ((r << 16) / d);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic ray_res_t predict_hit(logic [15:0] o [3], logic [15:0] d [3]);
    longint dl [3];
    longint e, f, h, t1, t2, tn, tf, a, tmp;
    bit hit;
    ray_res_t r;
    tn = -TMAX; tf = TMAX; hit = 1;
    for (int k = 0; k < 3; k++) dl[k] = sx16(o[k]) - sx16(box[REG_CENTER][16*k +: 16]);
    for (int i = 0; i < 3; i++) begin
      if (hit) begin
        e = 0; f = 0;
        for (int k = 0; k < 3; k++) begin
          a = sx16(box[REG_AXIS_A+i][16*k +: 16]);
          e += a * dl[k];
          f += a * sx16(d[k]);
        end
        h = longint'(box[REG_HALF][16*i +: 16]) * 16384;
        if (f == 0) begin
          if (e < -h || e > h) hit = 0;
        end else begin
          t1 = slab_t(-h - e, f);
          t2 = slab_t(h - e, f);
          if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
          if (t1 > tn) tn = t1;
          if (t2 < tf) tf = t2;
          if (tn > tf) hit = 0;
        end
      end
    end
    if (hit && tf < 0) hit = 0;
    r = '0;
    if (hit) begin
      r.hit = 1;
      r.t_near = tn >= 0 ? tn[31:0] : 32'd0;
      r.t_far = tf[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at result %0d: got %h want %h", what, results_seen, got, want);
    errors++;
  endtask

  task automatic write_box(reg_idx_t idx, logic [47:0] v);
    psel <= 1; pwrite <= 1; paddr <= APB_ADDR_W'(8 * idx); pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    box[idx] = v;
  endtask

  task automatic send_ray(logic [15:0] o [3], logic [15:0] d [3]);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {d[2], d[1], d[0], o[2], o[1], o[0]};
    hit_queue.push_back(predict_hit(o, d));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rays_sent++;
  endtask

  task automatic end_stream();
    s_tvalid <= 0;
  endtask

  task automatic drain();
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (TB + 20) @(posedge clk);
  endtask

  // result side: bursty backpressure, compare against oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        ray_res_t w;
        if (hit_queue.size() == 0) begin
          report_mismatch("unexpected result", longint'(m_tdata), 64'd0);
        end else begin
          w = hit_queue.pop_front();
          if (m_tuser !== w.hit)
            report_mismatch("hit", longint'(m_tuser), longint'(w.hit));
          if (m_tdata[31:0] !== w.t_near)
            report_mismatch("t_near", longint'(m_tdata[31:0]), longint'(w.t_near));
          if (m_tdata[63:32] !== w.t_far)
            report_mismatch("t_far", longint'(m_tdata[63:32]), longint'(w.t_far));
          if (w.hit) hits_seen++;
        end
        results_seen++;
      end
      if (quiet) begin
        m_tready <= 1'b1;
        out_stall <= 0;
      end else if (out_stall > 0) begin
        m_tready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if ($urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        out_stall <= int'($urandom_range(0, 3));
      end else begin
        m_tready <= 1'b1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      2: return 16'h0;
      default: return 16'($signed($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  function automatic logic [47:0] rnd_axes_word(bit unit, int lanepos);
    logic [47:0] v;
    if (unit) begin
      v = '0;
      v[16*lanepos +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
    end else begin
      v = {16'($urandom), 16'($urandom), 16'($urandom)};
    end
    return v;
  endfunction

  initial begin
    ray_row_t rows [$];
    ray_row_t rw;
    logic [15:0] o [3], d [3];
    box[REG_CENTER] = CENTER_RST; box[REG_AXIS_A] = AXIS_A_RST;
    box[REG_AXIS_B] = AXIS_B_RST; box[REG_AXIS_C] = AXIS_C_RST; box[REG_HALF] = HALF_RST;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table: default unit box, half-extent 1.0
    rw.chk = 1;
    // parallel on all three slabs, origin inside: t 0 .. TMAX
    rw.o = '{16'h0, 16'h0, 16'h0}; rw.d = '{16'h0, 16'h0, 16'h0};
    rw.res = '{1'b1, 32'h0, 32'hFFFF_FFFF}; rows.push_back(rw);
    // parallel and outside
    rw.o = '{16'h0200, 16'h0, 16'h0}; rw.res = '0; rows.push_back(rw);
    // from -2 along +x at unit speed: enter 1.0, exit 3.0
    rw.o = '{16'hFE00, 16'h0, 16'h0}; rw.d = '{16'h0100, 16'h0, 16'h0};
    rw.res = '{1'b1, 32'h0001_0000, 32'h0003_0000}; rows.push_back(rw);
    // box behind the ray
    rw.o = '{16'h0200, 16'h0, 16'h0}; rw.res = '0; rows.push_back(rw);
    // from inside: entry clamped to zero
    rw.o = '{16'h0, 16'h0, 16'h0}; rw.res = '{1'b1, 32'h0, 32'h0001_0000}; rows.push_back(rw);
    rw.chk = 0;
    rw.o = '{16'h8000, 16'h8000, 16'h8000}; rw.d = '{16'h7FFF, 16'h7FFF, 16'h7FFF}; rows.push_back(rw);
    rw.o = '{16'h7FFF, 16'h7FFF, 16'h7FFF}; rw.d = '{16'h8000, 16'h8000, 16'h8000}; rows.push_back(rw);
    rw.o = '{16'hFF00, 16'h0, 16'h0}; rw.d = '{16'h0001, 16'h0, 16'h0}; rows.push_back(rw);
    rw.o = '{16'h8000, 16'h0, 16'h0}; rw.d = '{16'h0001, 16'h0, 16'h0}; rows.push_back(rw);
    rw.o = '{16'hFE00, 16'hFE00, 16'h0}; rw.d = '{16'h0100, 16'h0100, 16'h0}; rows.push_back(rw);
    rw.o = '{16'hFE00, 16'h0300, 16'h0}; rw.d = '{16'h0100, 16'h0, 16'h0}; rows.push_back(rw);
    rw.o = '{16'h0, 16'h0, 16'h0200}; rw.d = '{16'h0, 16'h0, 16'hFF00}; rows.push_back(rw);
    rw.o = '{16'h0100, 16'hFF00, 16'h0100}; rw.d = '{16'h0, 16'h0, 16'h0}; rows.push_back(rw);
    rw.o = '{16'hFFFF, 16'h0001, 16'h5555}; rw.d = '{16'hAAAA, 16'h0001, 16'hFFFF}; rows.push_back(rw);
    foreach (rows[i]) begin
      send_ray(rows[i].o, rows[i].d);
      if (rows[i].chk && hit_queue[$] !== rows[i].res)
        report_mismatch("table row", 64'(hit_queue[$]), 64'(rows[i].res));
    end
    end_stream();
    drain();

    // extremes of the box registers, then random boxes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_box(REG_CENTER, 48'h7FFF_8000_7FFF);
        write_box(REG_HALF, 48'hFFFF_FFFF_FFFF);
        write_box(REG_AXIS_A, 48'h0000_0000_4000);
        write_box(REG_AXIS_B, 48'h0000_C000_0000);
        write_box(REG_AXIS_C, 48'h4000_0000_0000);
      end else if (ph == 1) begin
        write_box(REG_CENTER, 48'h8000_7FFF_8000);
        write_box(REG_HALF, 48'h0);
        write_box(REG_AXIS_A, 48'hFFFF_FFFF_FFFF);
        write_box(REG_AXIS_B, 48'h8000_8000_8000);
        write_box(REG_AXIS_C, 48'h7FFF_7FFF_7FFF);
      end else begin
        bit unit;
        unit = ph < 6;
        write_box(REG_CENTER, {16'(rnd_coord()), 16'(rnd_coord()), 16'(rnd_coord())});
        write_box(REG_HALF, ph == 7 ? 48'($urandom) << 16 | 48'($urandom) :
                  {16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)),
                   16'($urandom_range(0, 2048))});
        write_box(REG_AXIS_A, rnd_axes_word(unit, 0));
        write_box(REG_AXIS_B, rnd_axes_word(unit, 1));
        write_box(REG_AXIS_C, rnd_axes_word(unit, 2));
      end
      quiet = ph == 7;
      for (int n = 0; n < 62; n++) begin
        for (int k = 0; k < 3; k++) begin
          o[k] = rnd_coord();
          d[k] = rnd_coord();
        end
        // aim most rays through the center so hits are common
        if ($urandom_range(0, 2) != 0)
          for (int k = 0; k < 3; k++) d[k] = 16'(sx16(box[REG_CENTER][16*k +: 16]) - sx16(o[k]));
        send_ray(o, d);
      end
      end_stream();
      drain();
    end

    $display("sent %0d rays over 9 box settings, %0d results, %0d hits",
             rays_sent, results_seen, hits_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/rosi_pkg.sv
rtl/rosi_cfg.sv
rtl/rosi_proj.sv
rtl/rosi_div.sv
rtl/rosi_resolve.sv
rtl/ray_obb_slab_intersect.sv
rtl/rosi_checker.sv
tb/testbench.sv
